### rtl/keyed_priority_event_queue_top_assert.svh
// assertion macros for the keyed priority event queue
`ifndef KEYED_PRIORITY_EVENT_QUEUE_TOP_ASSERT_SVH
`define KEYED_PRIORITY_EVENT_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kpq assertion failed");

// next-cycle implication, checked outside reset
`define KPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kpq assertion failed");

`endif

### rtl/kpq_pkg.sv
// types, codes and constants shared by the keyed priority event queue
package kpq_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned TIME_W   = 12;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_REMOVED  = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EXEC
  } state_e;

  // prio, time and id sit on top so the packed order is the service order
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] tm;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  pay;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam int unsigned ORDER_W = PRIO_W + TIME_W + ID_W;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/keyed_priority_event_queue_top.sv
// keyed priority event queue: add, pop-best and remove-by-id over a slot store
// a command beat runs through the scan, drain and exec states before its result beat is registered
// only one command is in flight at a time; its scan reads one slot per cycle
//   through the slot ram read port
// a finished result waits in the output register while the next command is taken
// reset clears slot valid bits, the count and all handshakes at once; no clearing pass
module keyed_priority_event_queue_top #(
  parameter int unsigned ENTRIES = kpq_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kpq_pkg::KIND_W-1:0]    kind_i,
  input  logic [kpq_pkg::ID_W-1:0]      event_id_i,
  input  logic [kpq_pkg::PRIO_W-1:0]    priority_req_i,
  input  logic [kpq_pkg::TIME_W-1:0]    event_time_i,
  input  logic [kpq_pkg::PAY_W-1:0]     payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kpq_pkg::STATUS_W-1:0]  status_o,
  output logic [kpq_pkg::ID_W-1:0]      out_id_o,
  output logic [kpq_pkg::PRIO_W-1:0]    out_priority_o,
  output logic [kpq_pkg::TIME_W-1:0]    out_time_o,
  output logic [kpq_pkg::PAY_W-1:0]     out_payload_o,
  output logic [kpq_pkg::OCC_W-1:0]     occupancy_o
);

  kpq_pkg::cmd_t  cmd;
  kpq_pkg::stat_t stat;

  kpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kpq_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .event_id_i     (event_id_i),
    .priority_req_i (priority_req_i),
    .event_time_i   (event_time_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_priority_o (out_priority_o),
    .out_time_o     (out_time_o),
    .out_payload_o  (out_payload_o),
    .occupancy_o    (occupancy_o)
  );

`include "keyed_priority_event_queue_top_assert.svh"

  // a command beat starts a scan, so the input side closes right after it
  `KPQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // an empty report only comes from an empty store
  `KPQ_ASSERT_SAME(a_empty_occ, clk_i, rst_ni, out_valid_o && (status_o == kpq_pkg::ST_EMPTY), occupancy_o == '0)
  // a full report only comes from a full store
  `KPQ_ASSERT_SAME(a_full_occ, clk_i, rst_ni, out_valid_o && (status_o == kpq_pkg::ST_FULL), occupancy_o == kpq_pkg::OCC_W'(ENTRIES))
  // event fields are zero unless an event was popped
  `KPQ_ASSERT_SAME(a_fields_zero, clk_i, rst_ni, out_valid_o && (status_o != kpq_pkg::ST_POPPED), (out_id_o == '0) && (out_priority_o == '0) && (out_time_o == '0) && (out_payload_o == '0))

endmodule

### rtl/kpq_ram.sv
// generic single-write, single-read ram with registered read data
module kpq_ram #(
  parameter int unsigned WIDTH = kpq_pkg::ENTRY_W,
  parameter int unsigned DEPTH = kpq_pkg::ENTRIES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kpq_ctrl.sv
// controller state machine: capture, scan, drain and commit sequencing
module kpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kpq_pkg::stat_t stat_i,
  output kpq_pkg::cmd_t  cmd_o
);

  kpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      kpq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = kpq_pkg::S_SCAN;
        end
      end
      kpq_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = kpq_pkg::S_DRAIN;
        end
      end
      // last read data is compared here
      kpq_pkg::S_DRAIN: begin
        state_d = kpq_pkg::S_EXEC;
      end
      kpq_pkg::S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = kpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/kpq_dp.sv
// datapath: command registers, slot store, scan compare, commit and result register
module kpq_dp #(
  parameter int unsigned ENTRIES = kpq_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kpq_pkg::cmd_t                 cmd_i,
  output kpq_pkg::stat_t                stat_o,
  input  logic [kpq_pkg::KIND_W-1:0]    kind_i,
  input  logic [kpq_pkg::ID_W-1:0]      event_id_i,
  input  logic [kpq_pkg::PRIO_W-1:0]    priority_req_i,
  input  logic [kpq_pkg::TIME_W-1:0]    event_time_i,
  input  logic [kpq_pkg::PAY_W-1:0]     payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kpq_pkg::STATUS_W-1:0]  status_o,
  output logic [kpq_pkg::ID_W-1:0]      out_id_o,
  output logic [kpq_pkg::PRIO_W-1:0]    out_priority_o,
  output logic [kpq_pkg::TIME_W-1:0]    out_time_o,
  output logic [kpq_pkg::PAY_W-1:0]     out_payload_o,
  output logic [kpq_pkg::OCC_W-1:0]     occupancy_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // command registers
  kpq_pkg::kind_e        kind_q;
  kpq_pkg::entry_t       req_q;

  // scan control
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         ridx_q;
  logic                  chk_q;

  // search results
  logic                  found_q, found_d;
  logic [IW-1:0]         found_idx_q, found_idx_d;
  logic                  free_found_q, free_found_d;
  logic [IW-1:0]         free_idx_q, free_idx_d;
  logic                  best_found_q, best_found_d;
  logic [IW-1:0]         best_idx_q, best_idx_d;
  kpq_pkg::entry_t       best_q, best_d;

  // slot state
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [CW-1:0]         count_q, count_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  kpq_pkg::status_e      status_q, status_d;
  kpq_pkg::entry_t       out_q, out_d;
  logic [CW+kpq_pkg::OCC_W-1:0] count_ext;

  // ram
  logic                      ram_we;
  logic [kpq_pkg::ENTRY_W-1:0] ram_rdata;
  kpq_pkg::entry_t           rd_entry;

  logic                  rd_v;
  logic                  hit;
  logic                  take_free;
  logic                  better;
  logic                  set_en, clr_en;
  logic [IW-1:0]         clr_idx;

  kpq_ram #(
    .WIDTH (kpq_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i (req_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = kpq_pkg::entry_t'(ram_rdata);

  assign stat_o.scan_last = (idx_q == LAST_IDX);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // compare one slot per cycle against the running results
  assign rd_v      = chk_q && valid_q[ridx_q];
  assign hit       = rd_v && (rd_entry.id == req_q.id);
  assign take_free = chk_q && !valid_q[ridx_q] && !free_found_q;
  assign better    = rd_v && (!best_found_q ||
                     (rd_entry[kpq_pkg::ENTRY_W-1 -: kpq_pkg::ORDER_W] <
                      best_q[kpq_pkg::ENTRY_W-1 -: kpq_pkg::ORDER_W]));

  always_comb begin
    idx_d        = idx_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    if (cmd_i.capture) begin
      idx_d        = '0;
      found_d      = 1'b0;
      free_found_d = 1'b0;
      best_found_d = 1'b0;
    end else begin
      if (cmd_i.scan && !stat_o.scan_last) begin
        idx_d = idx_q + 1'b1;
      end
      if (hit) begin
        found_d     = 1'b1;
        found_idx_d = ridx_q;
      end
      if (take_free) begin
        free_found_d = 1'b1;
        free_idx_d   = ridx_q;
      end
      if (better) begin
        best_found_d = 1'b1;
        best_idx_d   = ridx_q;
        best_d       = rd_entry;
      end
    end
  end

  // commit the command and build the result beat
  always_comb begin
    ram_we   = 1'b0;
    set_en   = 1'b0;
    clr_en   = 1'b0;
    clr_idx  = found_idx_q;
    count_d  = count_q;
    status_d = status_q;
    out_d    = out_q;
    valid_d  = valid_q;
    if (cmd_i.commit) begin
      out_d    = '0;
      status_d = kpq_pkg::ST_NOTFOUND;
      case (kind_q)
        kpq_pkg::KIND_ADD: begin
          if (found_q) begin
            status_d = kpq_pkg::ST_DUP;
          end else if (!free_found_q) begin
            status_d = kpq_pkg::ST_FULL;
          end else begin
            ram_we   = 1'b1;
            set_en   = 1'b1;
            count_d  = count_q + 1'b1;
            status_d = kpq_pkg::ST_ADDED;
          end
        end
        kpq_pkg::KIND_POP: begin
          if (!best_found_q) begin
            status_d = kpq_pkg::ST_EMPTY;
          end else begin
            clr_en   = 1'b1;
            clr_idx  = best_idx_q;
            count_d  = count_q - 1'b1;
            out_d    = best_q;
            status_d = kpq_pkg::ST_POPPED;
          end
        end
        kpq_pkg::KIND_REMOVE: begin
          if (found_q) begin
            clr_en   = 1'b1;
            count_d  = count_q - 1'b1;
            status_d = kpq_pkg::ST_REMOVED;
          end
        end
        default: begin
          status_d = kpq_pkg::ST_NOTFOUND;
        end
      endcase
    end
    if (set_en) begin
      valid_d[free_idx_q] = 1'b1;
    end
    if (clr_en) begin
      valid_d[clr_idx] = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      ridx_q       <= '0;
      chk_q        <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      valid_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      ridx_q       <= idx_q;
      chk_q        <= cmd_i.scan;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      best_found_q <= best_found_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q      <= kpq_pkg::kind_e'(kind_i);
      req_q.id    <= event_id_i;
      req_q.prio  <= priority_req_i;
      req_q.tm    <= event_time_i;
      req_q.pay   <= payload_i;
    end
    found_idx_q <= found_idx_d;
    free_idx_q  <= free_idx_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
    status_q    <= status_d;
    out_q       <= out_d;
  end

  // occupancy is the count masked to the port width
  assign count_ext      = {{kpq_pkg::OCC_W{1'b0}}, count_q};

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_id_o       = out_q.id;
  assign out_priority_o = out_q.prio;
  assign out_time_o     = out_q.tm;
  assign out_payload_o  = out_q.pay;
  assign occupancy_o    = count_ext[kpq_pkg::OCC_W-1:0];

endmodule

### bench/tb_keyed_priority_event_queue_top.sv
// self-checking testbench for the keyed priority event queue
module tb_keyed_priority_event_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kpq_pkg::*;

  localparam int unsigned SLOTS          = ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  typedef struct {
    status_e            status;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  tm;
    logic [PAY_W-1:0]   pay;
    logic [OCC_W-1:0]   occ;
  } outcome_t;

  // shadow copy of the slot store plus the results still owed by the block
  class event_store_model;
    bit                slot_used [SLOTS];
    logic [ID_W-1:0]   slot_key  [SLOTS];
    logic [PRIO_W-1:0] slot_prio [SLOTS];
    logic [TIME_W-1:0] slot_tm   [SLOTS];
    logic [PAY_W-1:0]  slot_pay  [SLOTS];
    int unsigned       held;
    outcome_t          owed_results[$];
    int                mismatches;

    function int pending();
      return owed_results.size();
    endfunction

    function void accept_command(kind_e k, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr,
                                 logic [TIME_W-1:0] tm, logic [PAY_W-1:0] pay);
      outcome_t res;
      int       hit;
      int       pick;
      res.status = ST_NOTFOUND;
      res.id     = '0;
      res.prio   = '0;
      res.tm     = '0;
      res.pay    = '0;
      hit  = -1;
      pick = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && slot_used[i] && slot_key[i] == id) hit = i;
      end
      case (k)
        KIND_ADD: begin
          if (hit >= 0) begin
            res.status = ST_DUP;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (pick < 0 && !slot_used[i]) pick = i;
            end
            if (pick < 0) begin
              res.status = ST_FULL;
            end else begin
              slot_used[pick] = 1'b1;
              slot_key[pick]  = id;
              slot_prio[pick] = pr;
              slot_tm[pick]   = tm;
              slot_pay[pick]  = pay;
              held++;
              res.status = ST_ADDED;
            end
          end
        end
        KIND_POP: begin
          // service order: priority, then time, then identifier
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && (pick < 0 || {slot_prio[i], slot_tm[i], slot_key[i]} <
                                 {slot_prio[pick], slot_tm[pick], slot_key[pick]}))
              pick = i;
          end
          if (pick < 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.id   = slot_key[pick];
            res.prio = slot_prio[pick];
            res.tm   = slot_tm[pick];
            res.pay  = slot_pay[pick];
            slot_used[pick] = 1'b0;
            if (held > 0) held--;
            res.status = ST_POPPED;
          end
        end
        KIND_REMOVE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            if (held > 0) held--;
            res.status = ST_REMOVED;
          end
        end
        default: res.status = ST_NOTFOUND;
      endcase
      res.occ = held[OCC_W-1:0];
      owed_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] pr, logic [TIME_W-1:0] tm,
                               logic [PAY_W-1:0] pay, logic [OCC_W-1:0] occ);
      outcome_t want;
      if (owed_results.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("out_id", 32'(want.id), 32'(id));
      compare_field("out_priority", 32'(want.prio), 32'(pr));
      compare_field("out_time", 32'(want.tm), 32'(tm));
      compare_field("out_payload", want.pay, pay);
      compare_field("occupancy", 32'(want.occ), 32'(occ));
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i         = '0;
  logic [ID_W-1:0]     event_id_i     = '0;
  logic [PRIO_W-1:0]   priority_req_i = '0;
  logic [TIME_W-1:0]   event_time_i   = '0;
  logic [PAY_W-1:0]    payload_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     out_id_o;
  logic [PRIO_W-1:0]   out_priority_o;
  logic [TIME_W-1:0]   out_time_o;
  logic [PAY_W-1:0]    out_payload_o;
  logic [OCC_W-1:0]    occupancy_o;

  event_store_model store_model = new;
  int unsigned      cycle_count = 0;
  int unsigned      rx_hold     = 0;
  logic [ID_W-1:0]  id_pool [24];
  int unsigned      fill_bias   = 50;

  keyed_priority_event_queue_top #(.ENTRIES(SLOTS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .event_id_i     (event_id_i),
    .priority_req_i (priority_req_i),
    .event_time_i   (event_time_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_priority_o (out_priority_o),
    .out_time_o     (out_time_o),
    .out_payload_o  (out_payload_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // beat monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        store_model.accept_command(kind_e'(kind_i), event_id_i, priority_req_i,
                                   event_time_i, payload_i);
      if (out_valid_o && out_ready_i)
        store_model.check_result(status_o, out_id_o, out_priority_o, out_time_o,
                                 out_payload_o, occupancy_o);
    end
  end

  // receiver: free-flowing stretches alternate with random stalls
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
    end else if (cycle_count[9]) begin
      out_ready_i = 1'b1;
      rx_hold     = 16;
    end else begin
      out_ready_i = !out_ready_i;
      rx_hold     = out_ready_i ? $urandom_range(0, 6) : $urandom_range(0, 24);
    end
  end

  task automatic issue(kind_e k, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr,
                       logic [TIME_W-1:0] tm, logic [PAY_W-1:0] pay);
    @(negedge clk_i);
    kind_i         = k;
    event_id_i     = id;
    priority_req_i = pr;
    event_time_i   = tm;
    payload_i      = pay;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic issue_random(output kind_e k);
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] pr;
    logic [TIME_W-1:0] tm;
    if ($urandom_range(99) < 3)
      k = KIND_RSVD;
    else if ($urandom_range(99) < fill_bias)
      k = KIND_ADD;
    else if ($urandom_range(4) < 3)
      k = KIND_POP;
    else
      k = KIND_REMOVE;
    // a small id pool keeps duplicates and removes landing on stored events
    id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(23)] : ID_W'($urandom);
    pr = ($urandom_range(1) == 0) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
    case ($urandom_range(3))
      0:       tm = TIME_W'($urandom);
      3:       tm = TIME_W'($urandom_range(0, 2) * 600);
      default: tm = TIME_W'($urandom_range(0, 2359));
    endcase
    issue(k, id, pr, tm, $urandom);
  endtask

  task automatic sender_gap(int unsigned cycles);
    @(negedge clk_i) in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  initial begin
    kind_e       k;
    int unsigned counted;
    int unsigned burst;
    int unsigned gap;
    bit          paused;
    counted = 0;
    paused  = 1'b0;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    issue(KIND_POP, 16'h0000, 8'h00, 12'h000, 32'h0);
    issue(KIND_REMOVE, 16'h1234, 8'h00, 12'h000, 32'h0);
    issue(KIND_RSVD, 16'hffff, 8'hff, 12'hfff, 32'hffff_ffff);
    issue(KIND_ADD, 16'h0000, 8'hff, 12'h000, 32'h0000_0000);
    issue(KIND_ADD, 16'hffff, 8'h00, 12'hfff, 32'hffff_ffff);
    issue(KIND_ADD, 16'hffff, 8'h10, 12'd100, 32'h1111_1111);
    // equal priority and time: identifier alone decides, added in falling order
    for (int i = 0; i < SLOTS - 2; i++)
      issue(KIND_ADD, ID_W'(16'h0200 - i), 8'd8, 12'd1200, 32'hcafe_0000 + i);
    issue(KIND_ADD, 16'h5555, 8'h01, 12'd1, 32'h5555_5555);
    issue(KIND_ADD, 16'h0000, 8'h01, 12'd1, 32'h0);
    issue(KIND_RSVD, 16'h0200, 8'h00, 12'h000, 32'h0);
    issue(KIND_POP, 16'h0000, 8'h00, 12'h000, 32'h0);
    issue(KIND_POP, 16'h0000, 8'h00, 12'h000, 32'h0);
    issue(KIND_REMOVE, 16'h0000, 8'h00, 12'h000, 32'h0);
    issue(KIND_REMOVE, 16'h0000, 8'h00, 12'h000, 32'h0);

    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0) fill_bias = ($urandom_range(2) == 0) ? 15 :
                                             ($urandom_range(1) == 0) ? 85 : 50;
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst; b++) begin
        issue_random(k);
        if (k != KIND_RSVD) counted++;
        if (!paused && counted >= RANDOM_ITEMS / 2) begin
          // hold off until the block has returned everything it owes
          @(negedge clk_i) in_valid_i = 1'b0;
          while (store_model.pending() != 0) @(posedge clk_i);
          paused = 1'b1;
        end
      end
      case ($urandom_range(9))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap != 0) sender_gap(gap);
    end

    @(negedge clk_i) in_valid_i = 1'b0;
    while (store_model.pending() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 8) @(posedge clk_i);
    if (store_model.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### keyed_priority_event_queue_top.f
+incdir+rtl
rtl/kpq_pkg.sv
rtl/kpq_ram.sv
rtl/kpq_ctrl.sv
rtl/kpq_dp.sv
rtl/keyed_priority_event_queue_top.sv
bench/tb_keyed_priority_event_queue_top.sv
